### rtl/kfu_pkg.sv
`timescale 1ns / 1ps

package kfu_pkg;

	// opcodes carried in s_tuser
	typedef enum logic [2:0] {
		OPC_LOAD_Q = 3'd0,
		OPC_LOAD_R = 3'd1,
		OPC_LOAD_X = 3'd2,
		OPC_LOAD_P = 3'd3,
		OPC_MEAS   = 3'd4
	} opc_t;

	// regions of the shared data RAM
	typedef enum logic [3:0] {
		RG_Q, RG_R, RG_P, RG_PC, RG_W, RG_K, RG_IK, RG_X, RG_Z, RG_IN, RG_END
	} region_t;

	// one result beat
	typedef struct packed {
		logic [2:0]         index;
		logic signed [31:0] value;
		logic               singular;
		logic               last;
	} rslt_t;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

	// word offset of a region; matrices row-major, work array is dim x 2*dim
	function automatic int unsigned kfu_base(input region_t rg, input int unsigned dim);
		int unsigned n2;
		n2 = dim * dim;
		case (rg)
			RG_Q:    return 0;
			RG_R:    return n2;
			RG_P:    return 2 * n2;
			RG_PC:   return 3 * n2;
			RG_W:    return 4 * n2;
			RG_K:    return 6 * n2;
			RG_IK:   return 7 * n2;
			RG_X:    return 8 * n2;
			RG_Z:    return 8 * n2 + dim;
			RG_IN:   return 8 * n2 + 2 * dim;
			default: return 8 * n2 + 3 * dim;
		endcase
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > SAT_MAX) return 32'sh7FFF_FFFF;
		if (v < SAT_MIN) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

### rtl/kfu_ram.sv
`timescale 1ns / 1ps

module kfu_ram #(
	parameter int DEPTH = 140,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/kfu_div.sv
`timescale 1ns / 1ps

module kfu_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);
	localparam logic [NW-1:0] POS_LIM = NW'(64'h7FFF_FFFF);
	localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);

	logic [NW-1:0] sh_q;
	logic [31:0]   rem_q;
	logic [31:0]   dmag_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [31:0]   nmag;
	logic [32:0]   trial;
	logic [33:0]   diff;
	logic          ge;

	assign nmag  = num[31] ? 32'(-num) : 32'(num);
	assign trial = {rem_q, sh_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, dmag_q};
	assign ge    = !diff[33];

	// control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// restoring shift-subtract on magnitudes
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= NW'(nmag) << FRAC_BITS;
			rem_q  <= '0;
			dmag_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q  <= num[31] ^ den[31];
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			sh_q  <= {sh_q[NW-2:0], ge};
		end
	end

	// sign and clamp
	always_comb begin
		if (neg_q) begin
			quo = (sh_q > NEG_LIM) ? 32'sh8000_0000 : -$signed(sh_q[31:0]);
		end else begin
			quo = (sh_q > POS_LIM) ? 32'sh7FFF_FFFF : $signed(sh_q[31:0]);
		end
	end

endmodule

### rtl/kfu_seq.sv
`timescale 1ns / 1ps

module kfu_seq #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16,
	parameter int AW        = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic [AW-1:0]   raddr,
	input  logic [31:0]     rdata,
	output logic            we,
	output logic [AW-1:0]   waddr,
	output logic [31:0]     wdata,
	output logic            res_valid,
	input  logic            res_ready,
	output kfu_pkg::rslt_t  res
);
	import kfu_pkg::*;

	localparam int IW = $clog2(2 * DIM);
	localparam logic [AW-1:0] B_Q  = AW'(kfu_base(RG_Q, DIM));
	localparam logic [AW-1:0] B_R  = AW'(kfu_base(RG_R, DIM));
	localparam logic [AW-1:0] B_P  = AW'(kfu_base(RG_P, DIM));
	localparam logic [AW-1:0] B_PC = AW'(kfu_base(RG_PC, DIM));
	localparam logic [AW-1:0] B_W  = AW'(kfu_base(RG_W, DIM));
	localparam logic [AW-1:0] B_K  = AW'(kfu_base(RG_K, DIM));
	localparam logic [AW-1:0] B_IK = AW'(kfu_base(RG_IK, DIM));
	localparam logic [AW-1:0] B_X  = AW'(kfu_base(RG_X, DIM));
	localparam logic [AW-1:0] B_Z  = AW'(kfu_base(RG_Z, DIM));
	localparam logic [AW-1:0] B_IN = AW'(kfu_base(RG_IN, DIM));
	localparam logic signed [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);
	localparam logic signed [63:0] HALF_Q = 64'(64'd1 << (FRAC_BITS - 1));
	localparam logic [IW-1:0] LAST_N = IW'(DIM - 1);
	localparam logic [IW-1:0] LAST_W = IW'(2 * DIM - 1);
	localparam logic [IW-1:0] COL_N  = IW'(DIM);
	localparam logic [IW-1:0] I1     = IW'(1);

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDB, S_CAP, S_MUL, S_MUL2, S_DIV, S_WR, S_WR2, S_EMIT
	} state_t;

	typedef enum logic [4:0] {
		PH_PRED1, PH_PRED2, PH_IDENT, PH_PIV, PH_SRCH, PH_SWAP, PH_NORM, PH_ONE,
		PH_FACT, PH_ELIM, PH_ZERO, PH_GAIN, PH_INNOV, PH_XMAC, PH_XADD, PH_IK,
		PH_PUPD, PH_OUT
	} phase_t;

	typedef enum logic [3:0] {
		OP_MOV, OP_ADD, OP_SUB, OP_RSUB, OP_MSUB, OP_MAC, OP_DIV, OP_CONST, OP_XADD
	} aluop_t;

	state_t  state_q;
	phase_t  ph_q;
	logic [IW-1:0] i_q, j_q, k_q, l_q, sw_q;
	logic          sing_q;

	logic signed [31:0] a_q, b_q, piv_q, f_q, res_val_q;
	logic signed [63:0] prod_s1, wide_s2, acc_q;

	logic [AW-1:0] adr_a, adr_b, adr_w, adr_w2;
	aluop_t        op;
	logic          wr_en;
	logic signed [31:0] cst;
	logic signed [31:0] r_val, msat, mul_y;
	logic signed [63:0] acc_n;
	logic i_end, j_end, l_end, k_end, jw_end;
	phase_t        nr_ph;
	logic [IW-1:0] nr_i, nr_k;
	logic          div_go, div_done;
	logic signed [31:0] div_q;

	function automatic logic [AW-1:0] madr(input logic [AW-1:0] base,
			input logic [IW-1:0] r, input logic [IW-1:0] c);
		return base + AW'(r) * AW'(DIM) + AW'(c);
	endfunction

	function automatic logic [AW-1:0] wadr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return B_W + AW'(r) * AW'(2 * DIM) + AW'(c);
	endfunction

	function automatic logic [AW-1:0] vadr(input logic [AW-1:0] base, input logic [IW-1:0] r);
		return base + AW'(r);
	endfunction

	assign i_end  = (i_q == LAST_N);
	assign j_end  = (j_q == LAST_N);
	assign l_end  = (l_q == LAST_N);
	assign k_end  = (k_q == LAST_N);
	assign jw_end = (j_q == LAST_W);

	// per-phase operand addresses and operation
	always_comb begin
		adr_a  = '0;
		adr_b  = '0;
		adr_w  = '0;
		adr_w2 = '0;
		op     = OP_MOV;
		wr_en  = 1'b0;
		cst    = (i_q == j_q) ? ONE_Q : '0;
		unique case (ph_q)
			PH_PRED1: begin
				adr_a = madr(B_P, i_q, j_q);
				adr_b = madr(B_Q, i_q, j_q);
				adr_w = madr(B_PC, i_q, j_q);
				op    = OP_ADD;
				wr_en = 1'b1;
			end
			PH_PRED2: begin
				adr_a = madr(B_PC, i_q, j_q);
				adr_b = madr(B_R, i_q, j_q);
				adr_w = wadr(i_q, j_q);
				op    = OP_ADD;
				wr_en = 1'b1;
			end
			PH_IDENT: begin
				adr_w = wadr(i_q, COL_N + j_q);
				op    = OP_CONST;
				wr_en = 1'b1;
			end
			PH_PIV: adr_a = wadr(k_q, k_q);
			PH_SRCH: adr_a = wadr(i_q, k_q);
			PH_SWAP: begin
				adr_a  = wadr(k_q, j_q);
				adr_b  = wadr(sw_q, j_q);
				adr_w  = wadr(k_q, j_q);
				adr_w2 = wadr(sw_q, j_q);
				wr_en  = 1'b1;
			end
			PH_NORM: begin
				adr_a = wadr(k_q, j_q);
				adr_w = wadr(k_q, j_q);
				op    = OP_DIV;
				wr_en = 1'b1;
			end
			PH_ONE: begin
				adr_w = wadr(k_q, k_q);
				op    = OP_CONST;
				cst   = ONE_Q;
				wr_en = 1'b1;
			end
			PH_FACT: adr_a = wadr(i_q, k_q);
			PH_ELIM: begin
				adr_a = wadr(i_q, j_q);
				adr_b = wadr(k_q, j_q);
				adr_w = wadr(i_q, j_q);
				op    = OP_MSUB;
				wr_en = 1'b1;
			end
			PH_ZERO: begin
				adr_w = wadr(i_q, k_q);
				op    = OP_CONST;
				cst   = '0;
				wr_en = 1'b1;
			end
			PH_GAIN: begin
				adr_a = madr(B_PC, i_q, l_q);
				adr_b = wadr(l_q, COL_N + j_q);
				adr_w = madr(B_K, i_q, j_q);
				op    = OP_MAC;
				wr_en = l_end;
			end
			PH_INNOV: begin
				adr_a = vadr(B_Z, i_q);
				adr_b = vadr(B_X, i_q);
				adr_w = vadr(B_IN, i_q);
				op    = OP_SUB;
				wr_en = 1'b1;
			end
			PH_XMAC: begin
				adr_a = madr(B_K, i_q, l_q);
				adr_b = vadr(B_IN, l_q);
				op    = OP_MAC;
			end
			PH_XADD: begin
				adr_a = vadr(B_X, i_q);
				adr_w = vadr(B_X, i_q);
				op    = OP_XADD;
				wr_en = 1'b1;
			end
			PH_IK: begin
				adr_a = madr(B_K, i_q, j_q);
				adr_w = madr(B_IK, i_q, j_q);
				op    = OP_RSUB;
				wr_en = 1'b1;
			end
			PH_PUPD: begin
				adr_a = madr(B_IK, i_q, l_q);
				adr_b = madr(B_PC, l_q, j_q);
				adr_w = madr(B_P, i_q, j_q);
				op    = OP_MAC;
				wr_en = l_end;
			end
			PH_OUT: adr_a = vadr(B_X, i_q);
			default: ;
		endcase
	end

	// shared ALU result
	assign acc_n = ((l_q == '0) ? 64'sd0 : acc_q) + wide_s2;
	assign msat  = sat32(wide_s2);
	assign mul_y = (op == OP_MSUB) ? f_q : a_q;

	always_comb begin
		case (op)
			OP_ADD:   r_val = sat32(64'(a_q) + 64'(b_q));
			OP_SUB:   r_val = sat32(64'(a_q) - 64'(b_q));
			OP_RSUB:  r_val = sat32(64'(cst) - 64'(a_q));
			OP_MSUB:  r_val = sat32(64'(a_q) - 64'(msat));
			OP_MAC:   r_val = sat32(acc_n);
			OP_DIV:   r_val = div_q;
			OP_CONST: r_val = cst;
			OP_XADD:  r_val = sat32(64'(a_q) + 64'(sat32(acc_q)));
			default:  r_val = a_q;
		endcase
	end

	// next row of the elimination step
	always_comb begin
		if (i_end) begin
			nr_i = '0;
			if (k_end) begin
				nr_ph = PH_GAIN;
				nr_k  = k_q;
			end else begin
				nr_ph = PH_PIV;
				nr_k  = k_q + I1;
			end
		end else begin
			nr_i  = i_q + I1;
			nr_ph = PH_FACT;
			nr_k  = k_q;
		end
	end

	// RAM port
	assign raddr = (state_q == S_RDB) ? adr_b : adr_a;
	assign we    = (state_q == S_WR && wr_en) || (state_q == S_WR2);
	assign waddr = (state_q == S_WR2) ? adr_w2 : adr_w;
	assign wdata = (state_q == S_WR2) ? a_q : ((ph_q == PH_SWAP) ? b_q : r_val);

	assign div_go = (state_q == S_CAP) && (op == OP_DIV);

	kfu_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_go),
		.num   (a_q),
		.den   (piv_q),
		.done  (div_done),
		.quo   (div_q)
	);

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res       = '{index: 3'(i_q), value: res_val_q, singular: sing_q, last: i_end};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_PRED1;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			l_q     <= '0;
			sw_q    <= '0;
			sing_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RDA;
						ph_q    <= PH_PRED1;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						l_q     <= '0;
						sing_q  <= 1'b0;
					end
				end
				S_RDA: begin
					if (ph_q == PH_FACT && i_q == k_q) begin
						ph_q <= nr_ph;
						i_q  <= nr_i;
						k_q  <= nr_k;
						j_q  <= '0;
						l_q  <= '0;
					end else if (op == OP_CONST) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_RDB;
					end
				end
				S_RDB: state_q <= S_CAP;
				S_CAP: begin
					if (op == OP_MAC || op == OP_MSUB) state_q <= S_MUL;
					else if (op == OP_DIV) state_q <= S_DIV;
					else state_q <= S_WR;
				end
				S_MUL: state_q <= S_MUL2;
				S_MUL2: state_q <= S_WR;
				S_DIV: begin
					if (div_done) state_q <= S_WR;
				end
				S_WR: begin
					state_q <= S_RDA;
					unique case (ph_q)
						PH_PRED1, PH_PRED2, PH_IDENT, PH_IK: begin
							if (j_end) begin
								j_q <= '0;
								i_q <= i_end ? '0 : i_q + I1;
								if (i_end) begin
									unique case (ph_q)
										PH_PRED1: ph_q <= PH_PRED2;
										PH_PRED2: ph_q <= PH_IDENT;
										PH_IDENT: ph_q <= PH_PIV;
										default:  ph_q <= PH_PUPD;
									endcase
								end
							end else begin
								j_q <= j_q + I1;
							end
						end
						PH_PIV: begin
							if (a_q != '0) begin
								j_q  <= k_q + I1;
								ph_q <= PH_NORM;
							end else if (k_end) begin
								i_q    <= '0;
								ph_q   <= PH_OUT;
								sing_q <= 1'b1;
							end else begin
								i_q  <= k_q + I1;
								ph_q <= PH_SRCH;
							end
						end
						PH_SRCH: begin
							if (a_q != '0) begin
								sw_q <= i_q;
								j_q  <= '0;
								ph_q <= PH_SWAP;
							end else if (i_end) begin
								i_q    <= '0;
								ph_q   <= PH_OUT;
								sing_q <= 1'b1;
							end else begin
								i_q <= i_q + I1;
							end
						end
						PH_SWAP: state_q <= S_WR2;
						PH_NORM: begin
							if (jw_end) ph_q <= PH_ONE;
							else j_q <= j_q + I1;
						end
						PH_ONE: begin
							i_q  <= '0;
							ph_q <= PH_FACT;
						end
						PH_FACT: begin
							j_q  <= k_q + I1;
							ph_q <= PH_ELIM;
						end
						PH_ELIM: begin
							if (jw_end) ph_q <= PH_ZERO;
							else j_q <= j_q + I1;
						end
						PH_ZERO: begin
							ph_q <= nr_ph;
							i_q  <= nr_i;
							k_q  <= nr_k;
							j_q  <= '0;
							l_q  <= '0;
						end
						PH_GAIN, PH_PUPD: begin
							if (l_end) begin
								l_q <= '0;
								if (j_end) begin
									j_q <= '0;
									i_q <= i_end ? '0 : i_q + I1;
									if (i_end) ph_q <= (ph_q == PH_GAIN) ? PH_INNOV : PH_OUT;
								end else begin
									j_q <= j_q + I1;
								end
							end else begin
								l_q <= l_q + I1;
							end
						end
						PH_INNOV: begin
							if (i_end) begin
								i_q  <= '0;
								ph_q <= PH_XMAC;
							end else begin
								i_q <= i_q + I1;
							end
						end
						PH_XMAC: begin
							if (l_end) begin
								l_q  <= '0;
								ph_q <= PH_XADD;
							end else begin
								l_q <= l_q + I1;
							end
						end
						PH_XADD: begin
							j_q  <= '0;
							if (i_end) begin
								i_q  <= '0;
								ph_q <= PH_IK;
							end else begin
								i_q  <= i_q + I1;
								ph_q <= PH_XMAC;
							end
						end
						default: state_q <= S_EMIT;
					endcase
				end
				S_WR2: begin
					state_q <= S_RDA;
					if (jw_end) ph_q <= PH_PIV;
					else j_q <= j_q + I1;
				end
				S_EMIT: begin
					if (res_ready) begin
						if (i_end) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + I1;
							state_q <= S_RDA;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand and multiplier registers
	always_ff @(posedge clk) begin
		if (state_q == S_RDB) a_q <= rdata;
		if (state_q == S_CAP) b_q <= rdata;
		if (state_q == S_MUL) prod_s1 <= b_q * mul_y;
		if (state_q == S_MUL2) wide_s2 <= (prod_s1 + HALF_Q) >>> FRAC_BITS;
		if (state_q == S_WR) begin
			if (op == OP_MAC) acc_q <= acc_n;
			if (ph_q == PH_PIV) piv_q <= a_q;
			if (ph_q == PH_FACT) f_q <= a_q;
			if (ph_q == PH_OUT) res_val_q <= a_q;
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("update started while sequencer busy");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	a_sing_out: assert property (@(posedge clk) disable iff (!arst_n)
		(sing_q && state_q != S_IDLE) |-> ph_q == PH_OUT)
		else $error("singular flag set while update still running");

	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_ready && i_end) |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after last beat");

endmodule

### rtl/identity_model_kalman_update_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// s_axis   in   s_tvalid/s_tready  tdata: row, col, value; tuser: opcode; tlast: last
// m_axis   out  m_tvalid/m_tready  tdata: index, state_value; tuser: singular; tlast
//
// Load beats and measurement beats without tlast are written straight into the RAM.
// A measurement with tlast starts an update: every scalar step of the sequencer goes
// through the RAM's single read port and single write port, and each of the
// DIM*(3*DIM-1)/2 normalizing divides (22 at DIM=4) waits on the divider to finish.
// s_tready is low from the update start until the last state beat enters the output
// register; m_tready low stalls the sequencer at the output. Reset is asynchronous and
// clears control only; the stores hold nothing defined until written.
module identity_model_kalman_update_unit #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [2:0] row, [5:3] col, [37:6] value, [39:38] zero
	input  logic [2:0]  s_tuser,   // [2:0] opcode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [2:0] index, [34:3] state_value, [39:35] zero
	output logic [0:0]  m_tuser,   // [0] singular
	output logic        m_tlast
);
	import kfu_pkg::*;

	localparam int DEPTH = kfu_base(RG_END, DIM);
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] B_Q = AW'(kfu_base(RG_Q, DIM));
	localparam logic [AW-1:0] B_R = AW'(kfu_base(RG_R, DIM));
	localparam logic [AW-1:0] B_P = AW'(kfu_base(RG_P, DIM));
	localparam logic [AW-1:0] B_X = AW'(kfu_base(RG_X, DIM));
	localparam logic [AW-1:0] B_Z = AW'(kfu_base(RG_Z, DIM));

	opc_t        opc;
	logic [2:0]  row, col;
	logic [31:0] value;
	logic        acc_in, row_ok, col_ok;
	logic        ld_we;
	logic [AW-1:0] ld_addr, mat_off;
	logic        start, busy;

	logic [AW-1:0] raddr, sq_waddr, waddr;
	logic [31:0]   rdata, sq_wdata, wdata;
	logic          sq_we, we;

	logic   res_valid, res_ready;
	rslt_t  res, out_q;
	logic   out_valid_q;

	assign opc    = opc_t'(s_tuser);
	assign row    = s_tdata[2:0];
	assign col    = s_tdata[5:3];
	assign value  = s_tdata[37:6];
	assign acc_in = s_tvalid && s_tready;
	assign row_ok = ({1'b0, row} < 4'(DIM));
	assign col_ok = ({1'b0, col} < 4'(DIM));
	assign mat_off = AW'(row) * AW'(DIM) + AW'(col);

	// load and measurement writes
	always_comb begin
		ld_we   = 1'b0;
		ld_addr = '0;
		unique case (opc)
			OPC_LOAD_Q: begin
				ld_we   = row_ok && col_ok;
				ld_addr = B_Q + mat_off;
			end
			OPC_LOAD_R: begin
				ld_we   = row_ok && col_ok;
				ld_addr = B_R + mat_off;
			end
			OPC_LOAD_X: begin
				ld_we   = row_ok;
				ld_addr = B_X + AW'(row);
			end
			OPC_LOAD_P: begin
				ld_we   = row_ok && col_ok;
				ld_addr = B_P + mat_off;
			end
			OPC_MEAS: begin
				ld_we   = row_ok;
				ld_addr = B_Z + AW'(row);
			end
			default: ;
		endcase
	end

	assign start    = acc_in && (opc == OPC_MEAS) && s_tlast;
	assign s_tready = !busy;

	// RAM write port shared by loads and the sequencer
	assign we    = sq_we || (acc_in && ld_we);
	assign waddr = sq_we ? sq_waddr : ld_addr;
	assign wdata = sq_we ? sq_wdata : value;

	kfu_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	kfu_seq #(
		.DIM      (DIM),
		.FRAC_BITS(FRAC_BITS),
		.AW       (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.raddr    (raddr),
		.rdata    (rdata),
		.we       (sq_we),
		.waddr    (sq_waddr),
		.wdata    (sq_wdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_q.value, out_q.index};
	assign m_tuser  = out_q.singular;
	assign m_tlast  = out_q.last;

endmodule

### sim/tb_identity_model_kalman_update_unit.sv
`timescale 1ns / 1ps

module tb_identity_model_kalman_update_unit;
	import kfu_pkg::*;

	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int NN        = DIM * DIM;
	localparam int ONE_Q     = 1 << FRAC_BITS;
	localparam int WATCH_LIM = 40000;

	typedef struct {
		opc_t            op;
		logic [2:0]      row;
		logic [2:0]      col;
		logic [31:0]     value;
		logic            last;
		logic            sing_known;  // typed expectation for the singular flag
		logic            sing_exp;
	} beat_t;

	typedef struct {
		logic [2:0]  index;
		logic [31:0] value;
		logic        singular;
		logic        last;
	} state_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	identity_model_kalman_update_unit #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) uut (.*);

	// predictor copy of the filter stores
	int          st_x [DIM];
	int          st_p [NN];
	int          st_q [NN];
	int          st_r [NN];
	int          st_z [DIM];
	state_beat_t state_q[$];
	int          errors;
	int          n_updates;
	int          n_singular;
	int          n_checked;
	int          idle_cnt;
	bit          calm;
	bit          in_flight;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int sat(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return int'(v);
	endfunction

	// round half up, floor shift
	function automatic longint fx_mul_wide(input int a, input int b);
		longint p;
		p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_BITS - 1));
		return p >>> FRAC_BITS;
	endfunction

	function automatic int fx_div(input int a, input int b);
		return sat((longint'(a) <<< FRAC_BITS) / longint'(b));
	endfunction

	function automatic void fx_matmul(input int a [NN], input int b [NN], output int c [NN]);
		longint acc;
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				acc = 0;
				for (int k = 0; k < DIM; k++)
					acc += fx_mul_wide(a[i*DIM+k], b[k*DIM+j]);
				c[i*DIM+j] = sat(acc);
			end
	endfunction

	// one filter update; returns 1 when S has no usable pivot
	function automatic bit kalman_update();
		int     pc [NN];
		int     s [NN];
		int     inv [NN];
		int     gain [NN];
		int     ik [NN];
		int     pn [NN];
		int     innov [DIM];
		int     w [DIM][2*DIM];
		int     piv;
		int     sw;
		int     f;
		int     t;
		longint acc;
		for (int i = 0; i < NN; i++) begin
			pc[i] = sat(longint'(st_p[i]) + st_q[i]);
			s[i]  = sat(longint'(pc[i]) + st_r[i]);
		end
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				w[i][j]     = s[i*DIM+j];
				w[i][DIM+j] = (i == j) ? ONE_Q : 0;
			end
		// Gauss-Jordan with row swap on a zero pivot
		for (int k = 0; k < DIM; k++) begin
			piv = w[k][k];
			if (piv == 0) begin
				sw = -1;
				for (int i = k + 1; i < DIM; i++)
					if (sw < 0 && w[i][k] != 0) sw = i;
				if (sw < 0) return 1'b1;
				for (int j = 0; j < 2*DIM; j++) begin
					t = w[k][j]; w[k][j] = w[sw][j]; w[sw][j] = t;
				end
				piv = w[k][k];
			end
			for (int j = k + 1; j < 2*DIM; j++) w[k][j] = fx_div(w[k][j], piv);
			w[k][k] = ONE_Q;
			for (int i = 0; i < DIM; i++) begin
				if (i != k && w[i][k] != 0) begin
					f = w[i][k];
					for (int j = k + 1; j < 2*DIM; j++)
						w[i][j] = sat(longint'(w[i][j]) - sat(fx_mul_wide(w[k][j], f)));
					w[i][k] = 0;
				end
			end
		end
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) inv[i*DIM+j] = w[i][DIM+j];
		fx_matmul(pc, inv, gain);
		for (int i = 0; i < DIM; i++) innov[i] = sat(longint'(st_z[i]) - st_x[i]);
		for (int i = 0; i < DIM; i++) begin
			acc = 0;
			for (int j = 0; j < DIM; j++) acc += fx_mul_wide(gain[i*DIM+j], innov[j]);
			st_x[i] = sat(longint'(st_x[i]) + sat(acc));
		end
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++)
				ik[i*DIM+j] = sat(longint'((i == j) ? ONE_Q : 0) - gain[i*DIM+j]);
		fx_matmul(ik, pc, pn);
		st_p = pn;
		return 1'b0;
	endfunction

	// apply one accepted beat to the predictor, queue the state beats it causes
	function automatic void predict_beat(input beat_t b);
		bit          rin;
		bit          cin;
		bit          sing;
		int          v;
		state_beat_t e;
		rin = b.row < DIM;
		cin = b.col < DIM;
		v   = b.value;
		case (b.op)
			OPC_LOAD_Q: if (rin && cin) st_q[b.row*DIM+b.col] = v;
			OPC_LOAD_R: if (rin && cin) st_r[b.row*DIM+b.col] = v;
			OPC_LOAD_X: if (rin) st_x[b.row] = v;
			OPC_LOAD_P: if (rin && cin) st_p[b.row*DIM+b.col] = v;
			OPC_MEAS: begin
				if (rin) st_z[b.row] = v;
				if (b.last) begin
					sing = kalman_update();
					n_updates++;
					if (sing) n_singular++;
					if (b.sing_known && sing != b.sing_exp) begin
						$display("%0t: singular flag of table row: expected %0b actual %0b",
							$realtime, b.sing_exp, sing);
						errors++;
					end
					for (int i = 0; i < DIM; i++) begin
						e.index    = i;
						e.value    = st_x[i];
						e.singular = sing;
						e.last     = (i == DIM - 1);
						state_q.push_back(e);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// present one beat, hold it until accepted
	task automatic send_beat(input beat_t b);
		if (!calm && $urandom_range(99) < 39) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= b.op;
		s_tdata  <= {2'b00, b.value, b.col, b.row};
		s_tlast  <= b.last;
		do @(posedge clk); while (!s_tready);
		predict_beat(b);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (state_q.size() != 0) @(posedge clk);
	endtask

	function automatic beat_t mk(input opc_t op, input int r, input int c, input int v,
			input bit l);
		beat_t b;
		b.op = op; b.row = r; b.col = c; b.value = v; b.last = l;
		b.sing_known = 1'b0; b.sing_exp = 1'b0;
		return b;
	endfunction

	function automatic int rand_value();
		case ($urandom_range(5))
			0:       return $urandom;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 0;
			default: return int'($urandom_range(0, 4*ONE_Q)) - 2*ONE_Q;
		endcase
	endfunction

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 28);
		end
	end

	// state beat checker
	always @(posedge clk) begin
		state_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (state_q.size() == 0) begin
				$display("%0t: unexpected state beat idx %0d value %h", $realtime,
					m_tdata[2:0], m_tdata[34:3]);
				errors++;
			end else begin
				e = state_q.pop_front();
				if (m_tdata[2:0] !== e.index) begin
					$display("%0t: index expected %0d actual %0d", $realtime, e.index,
						m_tdata[2:0]);
					errors++;
				end
				if (m_tdata[34:3] !== e.value) begin
					$display("%0t: state_value[%0d] expected %h actual %h", $realtime,
						e.index, e.value, m_tdata[34:3]);
					errors++;
				end
				if (m_tuser[0] !== e.singular) begin
					$display("%0t: singular expected %0b actual %0b", $realtime,
						e.singular, m_tuser[0]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: last expected %0b actual %0b", $realtime, e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !in_flight) begin
			idle_cnt = 0;
		end else begin
			idle_cnt++;
			if (idle_cnt >= WATCH_LIM) begin
				$display("%0t: no beat moved for %0d cycles", $realtime, WATCH_LIM);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		beat_t tbl[$];
		beat_t b;
		int    n_rand;
		errors = 0; n_updates = 0; n_singular = 0; n_checked = 0;
		idle_cnt = 0; calm = 1'b0; in_flight = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = OPC_LOAD_Q; s_tlast = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		in_flight = 1'b1;

		// fill every store: Q, R, P zero, x and z small
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				send_beat(mk(OPC_LOAD_Q, i, j, 0, 1'b0));
				send_beat(mk(OPC_LOAD_R, i, j, 0, 1'b0));
				send_beat(mk(OPC_LOAD_P, i, j, 0, 1'b0));
			end
		for (int i = 0; i < DIM; i++) begin
			send_beat(mk(OPC_LOAD_X, i, 0, (i + 1) * ONE_Q, 1'b0));
			send_beat(mk(OPC_MEAS, i, 0, -i * ONE_Q, 1'b0));
		end

		// directed table
		b = mk(OPC_MEAS, 0, 0, ONE_Q, 1'b1);                 // all-zero S: singular
		b.sing_known = 1'b1; b.sing_exp = 1'b1;
		tbl.push_back(b);
		tbl.push_back(mk(OPC_LOAD_R, 0, 1, ONE_Q, 1'b0));    // zero pivot, swap rows
		tbl.push_back(mk(OPC_LOAD_R, 1, 0, ONE_Q, 1'b0));
		tbl.push_back(mk(OPC_LOAD_R, 2, 2, ONE_Q, 1'b0));
		tbl.push_back(mk(OPC_LOAD_R, 3, 3, ONE_Q, 1'b0));
		b = mk(OPC_MEAS, 1, 0, 3 * ONE_Q, 1'b1);
		b.sing_known = 1'b1; b.sing_exp = 1'b0;
		tbl.push_back(b);
		tbl.push_back(mk(OPC_LOAD_X, 0, 7, 32'h7FFF_FFFF, 1'b0));
		tbl.push_back(mk(OPC_LOAD_X, 3, 0, 32'h8000_0000, 1'b0));
		tbl.push_back(mk(OPC_LOAD_P, 0, 0, 32'h7FFF_FFFF, 1'b1)); // last on a load
		tbl.push_back(mk(OPC_LOAD_Q, 3, 3, ONE_Q, 1'b0));
		tbl.push_back(mk(OPC_LOAD_Q, 7, 0, 32'h1234_5678, 1'b0)); // out of range
		tbl.push_back(mk(OPC_LOAD_R, 0, 7, 32'hDEAD_BEEF, 1'b0));
		tbl.push_back(mk(OPC_LOAD_P, 5, 5, 32'hFFFF_FFFF, 1'b0));
		tbl.push_back(mk(OPC_LOAD_X, 4, 0, 32'h5555_5555, 1'b0));
		tbl.push_back(mk(opc_t'(3'd5), 0, 0, 32'hAAAA_AAAA, 1'b1)); // unused opcodes
		tbl.push_back(mk(opc_t'(3'd6), 1, 1, 32'h0, 1'b0));
		tbl.push_back(mk(opc_t'(3'd7), 7, 7, 32'hFFFF_FFFF, 1'b1));
		tbl.push_back(mk(OPC_MEAS, 0, 0, 32'h8000_0000, 1'b0));
		tbl.push_back(mk(OPC_MEAS, 3, 5, 32'h7FFF_FFFF, 1'b0));
		tbl.push_back(mk(OPC_MEAS, 6, 0, 32'h0F0F_0F0F, 1'b1)); // out-of-range last
		tbl.push_back(mk(OPC_MEAS, 2, 0, 32'hFFFF_0000, 1'b1)); // missing elements
		foreach (tbl[i]) send_beat(tbl[i]);

		// sender holds off until the filter has drained
		wait_drained();

		// random: mostly measurement rounds, loads and noise between them
		n_rand = 0;
		while (n_rand < 45) begin
			calm = (n_rand >= 10 && n_rand < 30);
			case ($urandom_range(9))
				0, 1, 2: begin
					b = mk(opc_t'($urandom_range(3)), $urandom_range(DIM - 1),
						$urandom_range(DIM - 1), rand_value(), $urandom_range(1));
					if ($urandom_range(3) != 0 && b.op != OPC_LOAD_X && b.row == b.col)
						b.value = $urandom_range(ONE_Q / 4, 8 * ONE_Q);
				end
				3: b = mk(opc_t'($urandom_range(7)), $urandom_range(7), $urandom_range(7),
						$urandom, $urandom_range(1));
				default: b = mk(OPC_MEAS, $urandom_range(DIM - 1), $urandom_range(7),
						rand_value(), ($urandom_range(5) == 0));
			endcase
			send_beat(b);
			n_rand++;
		end
		calm = 1'b0;

		wait_drained();
		repeat (200) @(posedge clk);
		$display("Covered %0d filter updates (%0d singular), %0d state beats checked,",
			n_updates, n_singular, n_checked);
		$display("with loads, out-of-range indexes, unused opcodes and both-side stalls.");
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
